@@ rtl/ffca_pkg.sv @@
// Package for the first-fit coalescing allocator.
// Holds sizes, entry types, status and register codes and the header adjustment function.
// No dependencies.
package ffca_pkg;

   localparam int MAX_LIVE     = 64;
   localparam int MAX_EXTENTS  = 65;
   localparam int HEADER_BYTES = 8;

   localparam int EXT_IDX_W = $clog2(MAX_EXTENTS);
   localparam int EXT_CNT_W = $clog2(MAX_EXTENTS + 1);
   localparam int REC_IDX_W = $clog2(MAX_LIVE);
   localparam int ADJ_W     = 8;

   localparam logic [23:0] ARENA_BYTES_RESET = 24'd65536;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_FIT  = 2'd1,
      STATUS_UNKNOWN = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   typedef enum logic {
      CSR_ARENA_BASE  = 1'b0,
      CSR_ARENA_BYTES = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_A_RD,
      S_A_CHK,
      S_F_RD,
      S_F_CHK,
      S_F_ERD,
      S_F_ECHK,
      S_F_DEC,
      S_SH_RD,
      S_SH_WR,
      S_INS,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [31:0] start;
      logic [23:0] size;
   } extent_type;

   typedef struct packed {
      logic [31:0]      address;
      logic [ADJ_W-1:0] adjust;
      logic [23:0]      size;
   } record_type;

   // Smallest adjustment of at least the header size that aligns addr + adjustment.
   function automatic logic [ADJ_W-1:0] header_adjust(input logic [31:0] addr,
                                                      input logic [2:0] lg);
      logic [ADJ_W:0] align;
      logic [ADJ_W:0] base;
      logic [ADJ_W:0] steps;
      align = (ADJ_W+1)'(1) << lg;
      base  = ({1'b0, (~addr[ADJ_W-1:0]) + 8'd1}) & (align - (ADJ_W+1)'(1));
      steps = '0;
      if (base < (ADJ_W+1)'(HEADER_BYTES)) begin
         steps = (((ADJ_W+1)'(HEADER_BYTES) - base + align - (ADJ_W+1)'(1)) >> lg) << lg;
      end
      return ADJ_W'(base + steps);
   endfunction

endpackage

@@ rtl/ffca_req_if.sv @@
// Request channel interface of the allocator: valid, ready and the request fields.
// Depends on nothing but the handshake convention.
interface ffca_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [23:0] request_bytes;
   logic [2:0]  align_log2;
   logic [31:0] release_address;

   modport source (output valid, action, request_bytes, align_log2, release_address,
                   input ready);
   modport sink (input valid, action, request_bytes, align_log2, release_address,
                 output ready);
endinterface

@@ rtl/ffca_rsp_if.sv @@
// Response channel interface of the allocator: valid, ready and the result fields.
// Depends on nothing but the handshake convention.
interface ffca_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] granted_address;
   logic [23:0] used_bytes;
   logic [6:0]  live_count;

   modport source (output valid, status, granted_address, used_bytes, live_count,
                   input ready);
   modport sink (input valid, status, granted_address, used_bytes, live_count,
                 output ready);
endinterface

@@ rtl/first_fit_coalescing_allocator.sv @@
// Top level of the first-fit coalescing allocator: extent and record memories and sequencer.
// Depends on ffca_pkg, ffca_req_if and ffca_rsp_if.
//
//   channel  direction  transfer
//   req      in         one allocate or free request
//   rsp      out        status, granted address, bytes in use, live count
//   csr      in         register write, index 0 arena base, 1 arena size
//
// An allocate reads and checks each extent it examines; a free reads and checks each record
// and each extent it examines, then uses S_F_DEC when its walk passes the last extent and S_INS
// to place an inserted extent. A table shift reads and writes each entry moved, and S_IDLE and
// S_DONE accept and answer. The extent memory has a single read port, read once per step.
// After reset or an arena base write the tables are reinitialized before requests are taken.
// A waiting response does not block the next request; a stalled one holds its completion.
module first_fit_coalescing_allocator
   import ffca_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   ffca_req_if.sink         req_channel,
   ffca_rsp_if.source       rsp_channel,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [31:0]      csr_wdata
);

   extent_type ext_mem [MAX_EXTENTS];
   record_type rec_mem [MAX_LIVE];

   logic                  ext_we;
   logic [EXT_IDX_W-1:0]  ext_waddr, ext_raddr;
   extent_type            ext_wdata, ext_rdata_ff;
   logic                  rec_we;
   logic [REC_IDX_W-1:0]  rec_waddr, rec_raddr;
   record_type            rec_wdata, rec_rdata_ff;

   state_type             state_ff, state_in;
   logic [EXT_CNT_W-1:0]  idx_ff, idx_in, count_ff, count_in, sh_k_ff, sh_k_in;
   logic [REC_IDX_W-1:0]  rec_idx_ff, rec_idx_in, slot_ff, slot_in;
   logic [23:0]           used_ff, used_in, arena_bytes_ff, arena_bytes_in;
   logic [6:0]            live_ff, live_in;
   logic [MAX_LIVE-1:0]   valid_ff, valid_in;
   logic                  pend_ff, pend_in, rsp_valid_ff, rsp_valid_in;
   logic [31:0]           init_start_ff, init_start_in;
   logic [23:0]           init_size_ff, init_size_in;

   logic                  act_ff, act_in, sh_up_ff, sh_up_in;
   logic [23:0]           rbytes_ff, rbytes_in, bsize_ff, bsize_in, prev_size_ff, prev_size_in;
   logic [2:0]            lg_ff, lg_in;
   logic [31:0]           addr_ff, addr_in, bstart_ff, bstart_in, prev_start_ff, prev_start_in;
   status_type            status_ff, status_in;
   logic [31:0]           granted_ff, granted_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [31:0]           rsp_granted_ff, rsp_granted_in;
   logic [23:0]           rsp_used_ff, rsp_used_in;
   logic [6:0]            rsp_live_ff, rsp_live_in;

   logic                  free_found;
   logic [REC_IDX_W-1:0]  free_slot;
   logic [ADJ_W-1:0]      adj;
   logic [24:0]           total;
   logic [23:0]           rem, taken;
   logic                  fit, take_all;
   logic [32:0]           bend;
   logic                  mp, mn, dec_cur, rec_match;

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int r = MAX_LIVE - 1; r >= 0; r--) begin
         if (!valid_ff[r]) begin
            free_found = 1'b1;
            free_slot  = REC_IDX_W'(r);
         end
      end
   end

   assign adj      = header_adjust(ext_rdata_ff.start, lg_ff);
   assign total    = {1'b0, rbytes_ff} + {{(25-ADJ_W){1'b0}}, adj};
   assign fit      = {1'b0, ext_rdata_ff.size} >= total;
   assign rem      = ext_rdata_ff.size - total[23:0];
   assign take_all = rem <= 24'(HEADER_BYTES);
   assign taken    = take_all ? ext_rdata_ff.size : total[23:0];

   assign bend      = {1'b0, bstart_ff} + {9'd0, bsize_ff};
   assign dec_cur   = (state_ff == S_F_ECHK);
   assign mp        = (idx_ff != '0) &&
                      (({1'b0, prev_start_ff} + {9'd0, prev_size_ff}) == {1'b0, bstart_ff});
   assign mn        = dec_cur && ({1'b0, ext_rdata_ff.start} == bend);
   assign rec_match = valid_ff[rec_idx_ff] && (rec_rdata_ff.address == addr_ff);

   assign req_channel.ready = (state_ff == S_IDLE) && !pend_ff;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      sh_k_in        = sh_k_ff;
      rec_idx_in     = rec_idx_ff;
      slot_in        = slot_ff;
      used_in        = used_ff;
      live_in        = live_ff;
      valid_in       = valid_ff;
      pend_in        = pend_ff;
      init_start_in  = init_start_ff;
      init_size_in   = init_size_ff;
      arena_bytes_in = arena_bytes_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_channel.ready;
      act_in         = act_ff;
      sh_up_in       = sh_up_ff;
      rbytes_in      = rbytes_ff;
      bsize_in       = bsize_ff;
      prev_size_in   = prev_size_ff;
      lg_in          = lg_ff;
      addr_in        = addr_ff;
      bstart_in      = bstart_ff;
      prev_start_in  = prev_start_ff;
      status_in      = status_ff;
      granted_in     = granted_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_used_in    = rsp_used_ff;
      rsp_live_in    = rsp_live_ff;
      ext_we         = 1'b0;
      ext_waddr      = idx_ff[EXT_IDX_W-1:0];
      ext_wdata      = ext_rdata_ff;
      ext_raddr      = idx_ff[EXT_IDX_W-1:0];
      rec_we         = 1'b0;
      rec_waddr      = free_slot;
      rec_wdata      = rec_rdata_ff;
      rec_raddr      = rec_idx_ff;

      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ARENA_BASE: begin
               pend_in       = 1'b1;
               init_start_in = csr_wdata;
               init_size_in  = arena_bytes_ff;
            end
            CSR_ARENA_BYTES: arena_bytes_in = csr_wdata[23:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (pend_ff) begin
               ext_we    = 1'b1;
               ext_waddr = '0;
               ext_wdata = '{start: init_start_ff, size: init_size_ff};
               count_in  = (init_size_ff != '0) ? EXT_CNT_W'(1) : '0;
               valid_in  = '0;
               used_in   = '0;
               live_in   = '0;
               if (!(csr_we && csr_index_type'(csr_index) == CSR_ARENA_BASE)) begin
                  pend_in = 1'b0;
               end
            end else if (req_channel.valid) begin
               act_in     = req_channel.action;
               rbytes_in  = req_channel.request_bytes;
               lg_in      = req_channel.align_log2;
               addr_in    = req_channel.release_address;
               idx_in     = '0;
               rec_idx_in = '0;
               granted_in = '0;
               if (req_channel.action) begin
                  state_in = S_F_RD;
               end else if (count_ff == '0) begin
                  status_in = STATUS_NO_FIT;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_A_RD;
               end
            end
         end
         S_A_RD: state_in = S_A_CHK;
         S_A_CHK: begin
            if (fit) begin
               if (!free_found) begin
                  status_in = STATUS_FULL;
                  state_in  = S_DONE;
               end else begin
                  rec_we     = 1'b1;
                  rec_waddr  = free_slot;
                  granted_in = ext_rdata_ff.start + {{(32-ADJ_W){1'b0}}, adj};
                  rec_wdata  = '{address: granted_in, adjust: adj, size: taken};
                  valid_in[free_slot] = 1'b1;
                  used_in    = used_ff + taken;
                  live_in    = live_ff + 7'd1;
                  status_in  = STATUS_OK;
                  if (take_all) begin
                     count_in = count_ff - EXT_CNT_W'(1);
                     sh_k_in  = idx_ff;
                     sh_up_in = 1'b0;
                     state_in = (idx_ff < count_in) ? S_SH_RD : S_DONE;
                  end else begin
                     ext_we    = 1'b1;
                     ext_wdata = '{start: ext_rdata_ff.start + {8'd0, total[23:0]}, size: rem};
                     state_in  = S_DONE;
                  end
               end
            end else if (idx_ff + EXT_CNT_W'(1) >= count_ff) begin
               status_in = STATUS_NO_FIT;
               state_in  = S_DONE;
            end else begin
               idx_in   = idx_ff + EXT_CNT_W'(1);
               state_in = S_A_RD;
            end
         end
         S_F_RD: state_in = S_F_CHK;
         S_F_CHK: begin
            if (rec_match) begin
               slot_in   = rec_idx_ff;
               bstart_in = addr_ff - {{(32-ADJ_W){1'b0}}, rec_rdata_ff.adjust};
               bsize_in  = rec_rdata_ff.size;
               idx_in    = '0;
               state_in  = (count_ff == '0) ? S_F_DEC : S_F_ERD;
            end else if (rec_idx_ff == REC_IDX_W'(MAX_LIVE - 1)) begin
               status_in = STATUS_UNKNOWN;
               state_in  = S_DONE;
            end else begin
               rec_idx_in = rec_idx_ff + REC_IDX_W'(1);
               state_in   = S_F_RD;
            end
         end
         S_F_ERD: state_in = S_F_ECHK;
         S_F_ECHK, S_F_DEC: begin
            if (dec_cur && ({1'b0, ext_rdata_ff.start} < bend)) begin
               prev_start_in = ext_rdata_ff.start;
               prev_size_in  = ext_rdata_ff.size;
               idx_in        = idx_ff + EXT_CNT_W'(1);
               state_in      = (idx_in >= count_ff) ? S_F_DEC : S_F_ERD;
            end else if (!mp && !mn && count_ff >= EXT_CNT_W'(MAX_EXTENTS)) begin
               status_in = STATUS_FULL;
               state_in  = S_DONE;
            end else begin
               status_in = STATUS_OK;
               valid_in[slot_ff] = 1'b0;
               used_in   = used_ff - bsize_ff;
               live_in   = (live_ff != '0) ? live_ff - 7'd1 : live_ff;
               state_in  = S_DONE;
               if (mp) begin
                  ext_we    = 1'b1;
                  ext_waddr = EXT_IDX_W'(idx_ff - EXT_CNT_W'(1));
                  ext_wdata = '{start: prev_start_ff,
                                size: prev_size_ff + bsize_ff + (mn ? ext_rdata_ff.size : '0)};
                  if (mn) begin
                     count_in = count_ff - EXT_CNT_W'(1);
                     sh_k_in  = idx_ff;
                     sh_up_in = 1'b0;
                     state_in = (idx_ff < count_in) ? S_SH_RD : S_DONE;
                  end
               end else if (mn) begin
                  ext_we    = 1'b1;
                  ext_wdata = '{start: bstart_ff, size: ext_rdata_ff.size + bsize_ff};
               end else begin
                  count_in = count_ff + EXT_CNT_W'(1);
                  sh_k_in  = count_ff;
                  sh_up_in = 1'b1;
                  state_in = (count_ff == idx_ff) ? S_INS : S_SH_RD;
               end
            end
         end
         S_SH_RD: begin
            ext_raddr = sh_up_ff ? EXT_IDX_W'(sh_k_ff - EXT_CNT_W'(1))
                                 : EXT_IDX_W'(sh_k_ff + EXT_CNT_W'(1));
            state_in  = S_SH_WR;
         end
         S_SH_WR: begin
            ext_we    = 1'b1;
            ext_waddr = sh_k_ff[EXT_IDX_W-1:0];
            ext_wdata = ext_rdata_ff;
            if (sh_up_ff) begin
               sh_k_in  = sh_k_ff - EXT_CNT_W'(1);
               state_in = (sh_k_ff == idx_ff + EXT_CNT_W'(1)) ? S_INS : S_SH_RD;
            end else begin
               sh_k_in  = sh_k_ff + EXT_CNT_W'(1);
               state_in = (sh_k_in < count_ff) ? S_SH_RD : S_DONE;
            end
         end
         S_INS: begin
            ext_we    = 1'b1;
            ext_wdata = '{start: bstart_ff, size: bsize_ff};
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_channel.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_granted_in = (status_ff == STATUS_OK) ? granted_ff : '0;
               rsp_used_in    = used_ff;
               rsp_live_in    = live_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ext_we) begin
         ext_mem[ext_waddr] <= ext_wdata;
      end
      ext_rdata_ff <= ext_mem[ext_raddr];
      if (rec_we) begin
         rec_mem[rec_waddr] <= rec_wdata;
      end
      rec_rdata_ff <= rec_mem[rec_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         used_ff        <= '0;
         live_ff        <= '0;
         valid_ff       <= '0;
         pend_ff        <= 1'b1;
         init_start_ff  <= '0;
         init_size_ff   <= ARENA_BYTES_RESET;
         arena_bytes_ff <= ARENA_BYTES_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         used_ff        <= used_in;
         live_ff        <= live_in;
         valid_ff       <= valid_in;
         pend_ff        <= pend_in;
         init_start_ff  <= init_start_in;
         init_size_ff   <= init_size_in;
         arena_bytes_ff <= arena_bytes_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      sh_k_ff        <= sh_k_in;
      rec_idx_ff     <= rec_idx_in;
      slot_ff        <= slot_in;
      act_ff         <= act_in;
      sh_up_ff       <= sh_up_in;
      rbytes_ff      <= rbytes_in;
      bsize_ff       <= bsize_in;
      prev_size_ff   <= prev_size_in;
      lg_ff          <= lg_in;
      addr_ff        <= addr_in;
      bstart_ff      <= bstart_in;
      prev_start_ff  <= prev_start_in;
      status_ff      <= status_in;
      granted_ff     <= act_in ? '0 : granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_used_ff    <= rsp_used_in;
      rsp_live_ff    <= rsp_live_in;
   end

   assign rsp_channel.valid           = rsp_valid_ff;
   assign rsp_channel.status          = rsp_status_ff;
   assign rsp_channel.granted_address = rsp_granted_ff;
   assign rsp_channel.used_bytes      = rsp_used_ff;
   assign rsp_channel.live_count      = rsp_live_ff;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the first-fit coalescing allocator.
// Depends on ffca_pkg, ffca_req_if, ffca_rsp_if and the allocator RTL; a class predicts
// every response from its own copy of the free extent and record tables.
module testbench;
   import ffca_pkg::*;

   localparam longint CYCLE_LIMIT = 6000000;

   typedef struct {
      status_type  status;
      logic [31:0] granted;
      logic [23:0] used;
      logic [6:0]  live;
   } alloc_outcome;

   class arena_scoreboard;
      logic [31:0]  base_reg;
      logic [23:0]  bytes_reg;
      logic [31:0]  free_start[MAX_EXTENTS];
      logic [23:0]  free_size[MAX_EXTENTS];
      int           free_count;
      logic [31:0]  rec_addr[MAX_LIVE];
      logic [7:0]   rec_adj[MAX_LIVE];
      logic [23:0]  rec_size[MAX_LIVE];
      bit           rec_live[MAX_LIVE];
      logic [23:0]  in_use;
      int           live_total;
      logic [31:0]  last_granted;
      alloc_outcome pending[$];
      int           errors;
      int           status_seen[4];

      function new();
         errors = 0;
         base_reg = '0;
         bytes_reg = ARENA_BYTES_RESET;
         foreach (status_seen[s]) status_seen[s] = 0;
         rebuild();
      endfunction

      function void rebuild();
         foreach (rec_live[r]) rec_live[r] = 0;
         free_start[0] = base_reg;
         free_size[0] = bytes_reg;
         free_count = (bytes_reg != 0) ? 1 : 0;
         in_use = '0;
         live_total = 0;
      endfunction

      function void configure(csr_index_type idx, logic [31:0] data);
         if (idx == CSR_ARENA_BASE) begin
            base_reg = data;
            rebuild();
         end else begin
            bytes_reg = data[23:0];
         end
      endfunction

      function longint unsigned align_pad(logic [31:0] addr, logic [2:0] lg);
         longint unsigned align, pad;
         align = 64'd1 << lg;
         pad = (align - (addr & (align - 1))) & (align - 1);
         while (pad < HEADER_BYTES) pad += align;
         return pad;
      endfunction

      function void drop_extent(int i);
         for (int k = i; k + 1 < free_count; k++) begin
            free_start[k] = free_start[k + 1];
            free_size[k] = free_size[k + 1];
         end
         free_count--;
      endfunction

      function status_type allocate(logic [23:0] want, logic [2:0] lg);
         longint unsigned pad, total, have;
         logic [31:0] start;
         int r;
         for (int i = 0; i < free_count; i++) begin
            pad = align_pad(free_start[i], lg);
            total = want + pad;
            have = free_size[i];
            if (have < total) continue;
            r = -1;
            for (int k = 0; k < MAX_LIVE; k++)
               if (!rec_live[k] && r < 0) r = k;
            if (r < 0) return STATUS_FULL;
            start = free_start[i];
            if (have - total <= HEADER_BYTES) begin
               total = have;
               drop_extent(i);
            end else begin
               free_start[i] = start + total[31:0];
               free_size[i] = 24'(have - total);
            end
            last_granted = start + pad[31:0];
            rec_live[r] = 1;
            rec_addr[r] = last_granted;
            rec_adj[r] = pad[7:0];
            rec_size[r] = total[23:0];
            in_use = in_use + total[23:0];
            live_total++;
            return STATUS_OK;
         end
         return STATUS_NO_FIT;
      endfunction

      function status_type release_block(logic [31:0] addr);
         int r, i;
         logic [31:0] bstart;
         logic [23:0] bsize;
         longint unsigned bend;
         bit join_lo, join_hi;
         r = -1;
         for (int k = 0; k < MAX_LIVE; k++)
            if (rec_live[k] && rec_addr[k] == addr && r < 0) r = k;
         if (r < 0) return STATUS_UNKNOWN;
         bstart = addr - {24'd0, rec_adj[r]};
         bsize = rec_size[r];
         bend = longint'(bstart) + bsize;
         i = 0;
         while (i < free_count && longint'(free_start[i]) < bend) i++;
         join_lo = i > 0 && longint'(free_start[i-1]) + free_size[i-1] == longint'(bstart);
         join_hi = i < free_count && longint'(free_start[i]) == bend;
         if (!join_lo && !join_hi && free_count >= MAX_EXTENTS) return STATUS_FULL;
         if (join_lo && join_hi) begin
            free_size[i-1] = free_size[i-1] + bsize + free_size[i];
            drop_extent(i);
         end else if (join_lo) begin
            free_size[i-1] = free_size[i-1] + bsize;
         end else if (join_hi) begin
            free_start[i] = bstart;
            free_size[i] = free_size[i] + bsize;
         end else begin
            for (int k = free_count; k > i; k--) begin
               free_start[k] = free_start[k-1];
               free_size[k] = free_size[k-1];
            end
            free_start[i] = bstart;
            free_size[i] = bsize;
            free_count++;
         end
         rec_live[r] = 0;
         in_use = in_use - bsize;
         if (live_total > 0) live_total--;
         return STATUS_OK;
      endfunction

      function void note_request(logic act, logic [23:0] want, logic [2:0] lg,
                                 logic [31:0] addr);
         alloc_outcome o;
         o.status = act ? release_block(addr) : allocate(want, lg);
         o.granted = (!act && o.status == STATUS_OK) ? last_granted : '0;
         o.used = in_use;
         o.live = live_total[6:0];
         status_seen[o.status]++;
         pending.push_back(o);
      endfunction

      function void check_response(logic [1:0] st, logic [31:0] ga, logic [23:0] ub,
                                   logic [6:0] lc);
         alloc_outcome o;
         if (pending.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         o = pending.pop_front();
         if (st !== o.status) begin
            $error("status: expected %0d, got %0d", o.status, st);
            errors++;
         end
         if (ga !== o.granted) begin
            $error("granted_address: expected %h, got %h", o.granted, ga);
            errors++;
         end
         if (ub !== o.used) begin
            $error("used_bytes: expected %0d, got %0d", o.used, ub);
            errors++;
         end
         if (lc !== o.live) begin
            $error("live_count: expected %0d, got %0d", o.live, lc);
            errors++;
         end
      endfunction

      function bit pick_live(output logic [31:0] addr);
         int idx[$];
         foreach (rec_live[r]) if (rec_live[r]) idx.push_back(r);
         if (idx.size() == 0) return 0;
         addr = rec_addr[idx[$urandom_range(0, idx.size() - 1)]];
         return 1;
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          csr_we;
   csr_index_type csr_index;
   logic [31:0]   csr_wdata;
   bit            calm;
   int            stall_left;
   longint        cycles = 0;
   int            sent;
   arena_scoreboard sb;

   ffca_req_if req_bus();
   ffca_rsp_if rsp_bus();

   first_fit_coalescing_allocator uut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_bus),
      .rsp_channel (rsp_bus),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (calm || p < 70) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.status, rsp_bus.granted_address,
                              rsp_bus.used_bytes, rsp_bus.live_count);
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            stall_left <= pick_gap();
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send(logic act, logic [23:0] want, logic [2:0] lg, logic [31:0] addr);
      int gap;
      req_bus.valid <= 1'b1;
      req_bus.action <= act;
      req_bus.request_bytes <= want;
      req_bus.align_log2 <= lg;
      req_bus.release_address <= addr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(act, want, lg, addr);
      sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.configure(idx, data);
      @(posedge clock);
   endtask

   task automatic new_arena(logic [31:0] base, logic [23:0] bytes);
      drain();
      write_reg(CSR_ARENA_BYTES, {8'd0, bytes});
      write_reg(CSR_ARENA_BASE, base);
      repeat (3) @(posedge clock);
   endtask

   function automatic logic [23:0] pick_size();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 24'($urandom_range(1, 48));
      if (p < 90) return 24'($urandom_range(1, 1024));
      if (p < 97) return 24'($urandom_range(1, 65536));
      return 24'($urandom_range(1, 24'hFFFFFF));
   endfunction

   task automatic random_traffic(int count, int alloc_pct);
      logic [31:0] addr;
      int p;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) drain();
         p = $urandom_range(0, 99);
         if (p < alloc_pct) begin
            send(1'b0, pick_size(), 3'($urandom_range(0, 7)), $urandom());
         end else if (p < 92 && sb.pick_live(addr)) begin
            send(1'b1, 24'($urandom()), 3'($urandom_range(0, 7)), addr);
         end else begin
            addr = $urandom();
            if ($urandom_range(0, 1) && sb.pick_live(addr)) addr = addr + 32'd1;
            send(1'b1, 24'($urandom()), 3'($urandom_range(0, 7)), addr);
         end
      end
   endtask

   initial begin
      logic [31:0] a0, a1, a2, whole;
      sb = new();
      sent = 0;
      calm = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_ARENA_BASE;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.action = 1'b0;
      req_bus.request_bytes = '0;
      req_bus.align_log2 = '0;
      req_bus.release_address = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send(1'b0, 24'd0, 3'd0, '0);
      a0 = sb.last_granted;
      send(1'b0, 24'd1, 3'd7, '0);
      a1 = sb.last_granted;
      send(1'b0, 24'hFFFFFF, 3'd0, '0);
      send(1'b0, 24'd100, 3'd3, '0);
      a2 = sb.last_granted;
      send(1'b1, '0, '0, 32'h0000_1234);
      send(1'b1, '0, '0, 32'hFFFF_FFFF);
      send(1'b1, '0, '0, a0);
      send(1'b1, '0, '0, a2);
      send(1'b1, '0, '0, a1);
      send(1'b1, '0, '0, a1);
      send(1'b0, 24'd65528, 3'd0, '0);
      whole = sb.last_granted;
      send(1'b0, 24'd1, 3'd0, '0);
      send(1'b1, '0, '0, whole);
      for (int k = 0; k < 8; k++) send(1'b0, 24'd5, k[2:0], '0);
      drain();
      random_traffic(330, 60);

      calm = 1;
      new_arena(32'hFFFF_FFFF, 24'hFFFFFF);
      send(1'b0, 24'hFFFFF0, 3'd0, '0);
      send(1'b1, '0, '0, sb.last_granted);
      calm = 0;
      random_traffic(330, 55);
      new_arena(32'h0000_1003, 24'd700);
      random_traffic(330, 55);
      new_arena(32'h0000_0000, 24'd0);
      random_traffic(20, 70);
      new_arena(32'h0000_0007, 24'd9);
      random_traffic(20, 70);
      calm = 1;
      new_arena(32'h8000_0000, 24'd4096);
      random_traffic(330, 55);
      calm = 0;
      new_arena(32'h0000_0000, 24'd65536);
      random_traffic(360, 80);

      drain();
      $display("%0d requests sent across seven arena settings; ok %0d, no fit %0d,",
               sent, sb.status_seen[STATUS_OK], sb.status_seen[STATUS_NO_FIT]);
      $display("unknown address %0d, table full %0d; %0d field mismatches.",
               sb.status_seen[STATUS_UNKNOWN], sb.status_seen[STATUS_FULL], sb.errors);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/ffca_pkg.sv
rtl/ffca_req_if.sv
rtl/ffca_rsp_if.sv
rtl/first_fit_coalescing_allocator.sv
tb/sv/testbench.sv
